[rtl/slr_pkg.sv]
// shared types and constants for the slope line rasterizer
// request payload structs, coordinate and fixed-point widths, helper functions
// no dependencies
package slr_pkg;

    localparam int COORD_BITS   = 11;
    localparam int FRAC_BITS    = 16;
    localparam int FRAME_BITS   = 12;
    localparam int COLOR_BITS   = 8;
    localparam int CFG_IDX_BITS = 1;

    localparam int SLOPE_BITS = FRAC_BITS + 1;
    localparam int DIV_BITS   = COORD_BITS + FRAC_BITS;
    localparam int ALU_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(DIV_BITS);

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(1920);
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(1080);

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        logic                  opcode;
        coord_t                start_x;
        coord_t                start_y;
        coord_t                end_x;
        coord_t                end_y;
        logic [COLOR_BITS-1:0] red_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] blue_in;
    } in_t;

    typedef struct packed {
        logic                  pixel_valid;
        logic                  pixel_visible;
        coord_t                pixel_x;
        coord_t                pixel_y;
        logic [COLOR_BITS-1:0] red_out;
        logic [COLOR_BITS-1:0] green_out;
        logic [COLOR_BITS-1:0] blue_out;
        logic                  last_pixel;
        logic                  line_idle;
    } out_t;

    function automatic coord_t get_major(point_t p, logic steep);
        return steep ? p.y : p.x;
    endfunction

    function automatic coord_t get_minor(point_t p, logic steep);
        return steep ? p.x : p.y;
    endfunction

    function automatic coord_t abs_diff(coord_t a, coord_t b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

[rtl/slope_line_rasterizer.sv]
// slope line rasterizer top level: start decode, sequencer, shared adder, pixel output
// depends on slr_pkg
//
// A start request latches the endpoints and color and returns an all-zero result,
// then the block is busy while a restoring divider for the slope takes one quotient
// bit per cycle, a shift-add multiply for the starting minor offset takes one
// multiplier bit per cycle, and a final state loads the accumulator, all on a single
// shared add/subtract unit. After that, step requests are taken one per cycle while
// the output is not stalled, each giving one pixel: endpoint one, endpoint two,
// then the interior in ascending major order, with the minor coordinate tracked by
// adding or subtracting the slope on the same unit.
// Configuration writes are always accepted.
module slope_line_rasterizer
    import slr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FRAME_BITS-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_t                     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_t                    out_data
);

    typedef enum logic [3:0] {
        S_READY = 4'b0001,
        S_DIV   = 4'b0010,
        S_MUL   = 4'b0100,
        S_ACC   = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ONE  = 4'b0010,
        PH_TWO  = 4'b0100,
        PH_INT  = 4'b1000
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [FRAME_BITS-1:0]   frame_width_reg;
    logic [FRAME_BITS-1:0]   frame_height_reg;
    point_t                  point_one_reg;
    point_t                  point_two_reg;
    logic [COLOR_BITS-1:0]   red_reg, green_reg, blue_reg;
    logic                    steep_reg;
    logic                    minor_desc_reg;
    logic                    major_desc_reg;
    coord_t                  big_reg;
    coord_t                  mult_reg;
    logic [COORD_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]     quot_reg;
    logic [SLOPE_BITS-1:0]   slope_reg;
    logic [ALU_BITS-1:0]     prod_reg;
    logic [DIV_BITS-1:0]     acc_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    coord_t                  cursor_reg, cursor_next;
    logic                    out_valid_reg;
    out_t                    out_data_reg;

    logic                    in_fire;
    logic                    is_start;

    // start decode
    coord_t                  dx, dy, big_in, small_in;
    logic                    steep_in;
    point_t                  p1_in, p2_in;

    // shared add/subtract unit
    logic [ALU_BITS-1:0]     op_a, op_b, alu_sum;
    logic                    op_sub;
    logic                    div_ok;
    logic [DIV_BITS-1:0]     quot_shift;

    // step decode
    coord_t                  maj1, maj2, hi, lo, minor_cur;
    logic                    interior, last_int, acc_step;
    out_t                    step_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_READY) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign is_start  = (in_data.opcode == OP_START);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        p1_in    = '{y: in_data.start_y, x: in_data.start_x};
        p2_in    = '{y: in_data.end_y, x: in_data.end_x};
        dx       = abs_diff(in_data.start_x, in_data.end_x);
        dy       = abs_diff(in_data.start_y, in_data.end_y);
        steep_in = (dy > dx);
        big_in   = steep_in ? dy : dx;
        small_in = steep_in ? dx : dy;
    end

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (state_reg)
            S_DIV:
            begin
                op_a   = ALU_BITS'({rem_reg, quot_reg[DIV_BITS-1]});
                op_b   = ALU_BITS'(big_reg);
                op_sub = 1'b1;
            end
            S_MUL:
            begin
                op_a = {prod_reg[ALU_BITS-2:0], 1'b0};
                op_b = mult_reg[COORD_BITS-1] ? ALU_BITS'(slope_reg) : '0;
            end
            S_ACC:
            begin
                op_a   = ALU_BITS'({get_minor(point_one_reg, steep_reg),
                                    {FRAC_BITS{1'b0}}});
                op_b   = prod_reg;
                op_sub = minor_desc_reg;
            end
            default:
            begin
                op_a   = ALU_BITS'(acc_reg);
                op_b   = ALU_BITS'(slope_reg);
                op_sub = minor_desc_reg ^ major_desc_reg;
            end
        endcase
        alu_sum = op_sub ? (op_a - op_b) : (op_a + op_b);
    end

    assign div_ok     = !alu_sum[ALU_BITS-1];
    assign quot_shift = {quot_reg[DIV_BITS-2:0], div_ok};

    always_comb
    begin
        maj1      = get_major(point_one_reg, steep_reg);
        maj2      = get_major(point_two_reg, steep_reg);
        hi        = (maj1 < maj2) ? maj2 : maj1;
        lo        = (maj1 < maj2) ? maj1 : maj2;
        interior  = ((hi - lo) >= COORD_BITS'(2));
        minor_cur = acc_reg[FRAC_BITS +: COORD_BITS];
        last_int  = (({1'b0, cursor_reg} + 1'b1) >= {1'b0, hi});

        step_res    = '0;
        phase_next  = phase_reg;
        cursor_next = cursor_reg;
        acc_step    = 1'b0;
        unique case (phase_reg)
            PH_ONE:
            begin
                step_res.pixel_valid = 1'b1;
                step_res.pixel_x     = point_one_reg.x;
                step_res.pixel_y     = point_one_reg.y;
                step_res.last_pixel  = (point_one_reg == point_two_reg);
                phase_next = (point_one_reg == point_two_reg) ? PH_IDLE : PH_TWO;
            end
            PH_TWO:
            begin
                step_res.pixel_valid = 1'b1;
                step_res.pixel_x     = point_two_reg.x;
                step_res.pixel_y     = point_two_reg.y;
                step_res.last_pixel  = !interior;
                if (interior)
                begin
                    cursor_next = lo + 1'b1;
                    phase_next  = PH_INT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_INT:
            begin
                step_res.pixel_valid = 1'b1;
                step_res.pixel_x     = steep_reg ? minor_cur : cursor_reg;
                step_res.pixel_y     = steep_reg ? cursor_reg : minor_cur;
                step_res.last_pixel  = last_int;
                if (last_int)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    cursor_next = cursor_reg + 1'b1;
                    acc_step    = 1'b1;
                end
            end
            default:
            begin
                step_res.line_idle = 1'b1;
                phase_next         = PH_IDLE;
            end
        endcase
        if (step_res.pixel_valid)
        begin
            step_res.pixel_visible = (FRAME_BITS'(step_res.pixel_x) < frame_width_reg) &&
                                     (FRAME_BITS'(step_res.pixel_y) < frame_height_reg);
            step_res.red_out   = red_reg;
            step_res.green_out = green_reg;
            step_res.blue_out  = blue_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_READY: if (in_fire && is_start) state_next = S_DIV;
            S_DIV:   if (cnt_reg == '0) state_next = S_MUL;
            S_MUL:   if (cnt_reg == '0) state_next = S_ACC;
            S_ACC:   state_next = S_READY;
            default: state_next = S_READY;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_READY;
            phase_reg        <= PH_IDLE;
            out_valid_reg    <= 1'b0;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= is_start ? PH_ONE : phase_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire && is_start)
                cnt_reg <= CNT_BITS'(DIV_BITS - 1);
            else if (state_reg == S_DIV && cnt_reg == '0)
                cnt_reg <= CNT_BITS'(COORD_BITS - 1);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= is_start ? '0 : step_res;
            if (is_start)
            begin
                point_one_reg  <= p1_in;
                point_two_reg  <= p2_in;
                red_reg        <= in_data.red_in;
                green_reg      <= in_data.green_in;
                blue_reg       <= in_data.blue_in;
                steep_reg      <= steep_in;
                minor_desc_reg <= get_minor(p2_in, steep_in) < get_minor(p1_in, steep_in);
                major_desc_reg <= get_major(p1_in, steep_in) > get_major(p2_in, steep_in);
                mult_reg       <= (get_major(p1_in, steep_in) > get_major(p2_in, steep_in))
                                  ? big_in - 1'b1 : COORD_BITS'(1);
                big_reg        <= big_in;
                rem_reg        <= '0;
                quot_reg       <= {small_in, {FRAC_BITS{1'b0}}};
                cursor_reg     <= '0;
            end
            else
            begin
                cursor_reg <= cursor_next;
                if (acc_step)
                    acc_reg <= alu_sum[DIV_BITS-1:0];
            end
        end
        unique case (state_reg)
            S_DIV:
            begin
                rem_reg  <= div_ok ? alu_sum[COORD_BITS-1:0]
                                   : {rem_reg[COORD_BITS-2:0], quot_reg[DIV_BITS-1]};
                quot_reg <= quot_shift;
                if (cnt_reg == '0)
                begin
                    slope_reg <= (big_reg == '0) ? '0 : quot_shift[SLOPE_BITS-1:0];
                    prod_reg  <= '0;
                end
            end
            S_MUL:
            begin
                prod_reg <= alu_sum;
                mult_reg <= {mult_reg[COORD_BITS-2:0], 1'b0};
            end
            S_ACC:
            begin
                acc_reg <= alu_sum[DIV_BITS-1:0];
            end
            default: ;
        endcase
    end

endmodule

[sim/slope_line_rasterizer_test.sv]
`timescale 1ns / 1ps
// self-checking bench for slope_line_rasterizer: queued request driver, pixel predictor,
// result monitor, and frame register phases with random idling on both channels
// depends on slr_pkg and the rasterizer rtl
module slope_line_rasterizer_test
    import slr_pkg::*;
();

    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 230;
    localparam int SETTLE_TICKS = 50;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_TICKS   = 400;
    localparam int REPORT_LIMIT = 10;
    localparam int LONG_SPAN    = 320;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

    typedef enum logic [3:0] {
        TRACE_IDLE     = 4'b0001,
        TRACE_FIRST    = 4'b0010,
        TRACE_SECOND   = 4'b0100,
        TRACE_INTERIOR = 4'b1000
    } trace_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [FRAME_BITS-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    in_t                     in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_t                    out_data;

    // predictor state
    logic [FRAME_BITS-1:0] width_q = FRAME_WIDTH_RESET;
    logic [FRAME_BITS-1:0] height_q = FRAME_HEIGHT_RESET;
    point_t                line_one = '0;
    point_t                line_two = '0;
    logic [SLOPE_BITS-1:0] slope_q = '0;
    logic                  steep_q = 1'b0;
    logic                  desc_q = 1'b0;
    coord_t                cursor_q = '0;
    logic [23:0]           line_rgb = '0;
    trace_t                trace_q = TRACE_IDLE;

    in_t  pending_reqs[$];
    out_t expected_pixels[$];
    out_t want;

    bit req_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int accepted_reqs = 0;
    int line_starts = 0;
    int pixel_count = 0;
    int results_checked = 0;
    int fail_count = 0;
    int frame_sets = 0;

    slope_line_rasterizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned coord_span(input coord_t a, input coord_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic coord_t major_of(input point_t p);
        return steep_q ? p.y : p.x;
    endfunction

    function automatic coord_t minor_of(input point_t p);
        return steep_q ? p.x : p.y;
    endfunction

    function automatic out_t make_pixel(input coord_t x, input coord_t y, input logic last);
        out_t pix;
        pix = '0;
        pix.pixel_valid   = 1'b1;
        pix.pixel_visible = (x < width_q) && (y < height_q);
        pix.pixel_x       = x;
        pix.pixel_y       = y;
        pix.red_out       = line_rgb[23:16];
        pix.green_out     = line_rgb[15:8];
        pix.blue_out      = line_rgb[7:0];
        pix.last_pixel    = last;
        return pix;
    endfunction

    function automatic out_t rasterize_request(input in_t req);
        out_t              pix;
        longint unsigned   dx, dy, major_span, minor_span;
        longint unsigned   a, b, lo, hi, k, off, base, acc, cur;
        logic              same, last;
        pix = '0;
        if (req.opcode == OP_START)
        begin
            line_one   = {req.start_y, req.start_x};
            line_two   = {req.end_y, req.end_x};
            line_rgb   = {req.red_in, req.green_in, req.blue_in};
            dx         = coord_span(req.start_x, req.end_x);
            dy         = coord_span(req.start_y, req.end_y);
            steep_q    = dy > dx;
            major_span = steep_q ? dy : dx;
            minor_span = steep_q ? dx : dy;
            desc_q     = minor_of(line_two) < minor_of(line_one);
            slope_q    = (major_span == 0) ? '0
                                           : SLOPE_BITS'((minor_span << FRAC_BITS) / major_span);
            cursor_q   = '0;
            trace_q    = TRACE_FIRST;
            return pix;
        end
        a  = major_of(line_one);
        b  = major_of(line_two);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        unique case (trace_q)
            TRACE_FIRST:
            begin
                same    = line_one == line_two;
                pix     = make_pixel(line_one.x, line_one.y, same);
                trace_q = same ? TRACE_IDLE : TRACE_SECOND;
            end
            TRACE_SECOND:
            begin
                pix = make_pixel(line_two.x, line_two.y, (hi - lo) < 2);
                if (hi - lo >= 2)
                begin
                    cursor_q = coord_t'(lo + 1);
                    trace_q  = TRACE_INTERIOR;
                end
                else
                begin
                    trace_q = TRACE_IDLE;
                end
            end
            TRACE_INTERIOR:
            begin
                cur  = cursor_q;
                k    = (cur > a) ? cur - a : a - cur;
                off  = slope_q * k;
                base = minor_of(line_one);
                base = base << FRAC_BITS;
                // descending minor clamps at zero
                acc  = desc_q ? ((off <= base) ? base - off : 0) : base + off;
                last = (cur + 1) >= hi;
                if (steep_q)
                    pix = make_pixel(coord_t'(acc >> FRAC_BITS), cursor_q, last);
                else
                    pix = make_pixel(cursor_q, coord_t'(acc >> FRAC_BITS), last);
                if (last)
                    trace_q = TRACE_IDLE;
                else
                    cursor_q = cursor_q + 1'b1;
            end
            default:
            begin
                pix.line_idle = 1'b1;
            end
        endcase
        return pix;
    endfunction

    function automatic string pixel_text(input out_t p);
        return $sformatf("valid %b vis %b x %0d y %0d rgb %h %h %h last %b idle %b",
                         p.pixel_valid, p.pixel_visible, p.pixel_x, p.pixel_y,
                         p.red_out, p.green_out, p.blue_out, p.last_pixel, p.line_idle);
    endfunction

    // step request, other fields are don't-care noise
    function automatic in_t step_req();
        in_t req;
        req.opcode   = OP_STEP;
        req.start_x  = coord_t'($urandom_range(0, COORD_MAX));
        req.start_y  = coord_t'($urandom_range(0, COORD_MAX));
        req.end_x    = coord_t'($urandom_range(0, COORD_MAX));
        req.end_y    = coord_t'($urandom_range(0, COORD_MAX));
        req.red_in   = 8'($urandom_range(0, 255));
        req.green_in = 8'($urandom_range(0, 255));
        req.blue_in  = 8'($urandom_range(0, 255));
        return req;
    endfunction

    task automatic add_start(input int x1, input int y1, input int x2, input int y2,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        in_t req;
        req          = step_req();
        req.opcode   = OP_START;
        req.start_x  = coord_t'(x1);
        req.start_y  = coord_t'(y1);
        req.end_x    = coord_t'(x2);
        req.end_y    = coord_t'(y2);
        req.red_in   = r;
        req.green_in = g;
        req.blue_in  = b;
        pending_reqs.push_back(req);
    endtask

    task automatic add_steps(input int n);
        repeat (n) pending_reqs.push_back(step_req());
    endtask

    function automatic int pick_anchor(input bit near_origin);
        int r;
        r = $urandom_range(0, 3);
        if (near_origin || r == 0)
            return $urandom_range(0, 15);
        if (r == 1)
            return $urandom_range(COORD_MAX - 15, COORD_MAX);
        return $urandom_range(0, COORD_MAX);
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 149);
        if (r == 0)
            return $urandom_range(64, LONG_SPAN);
        if (r < 20)
            return $urandom_range(13, 48);
        return $urandom_range(0, 10);
    endfunction

    task automatic add_random_line(input bit near_origin);
        int x1, y1, x2, y2, ddx, ddy, shape, pixels, steps;
        x1    = pick_anchor(near_origin);
        y1    = pick_anchor(near_origin);
        ddx   = pick_span();
        ddy   = pick_span();
        shape = $urandom_range(0, 9);
        if (shape == 0)
            ddy = 0;
        else if (shape == 1)
            ddx = 0;
        x2 = ($urandom_range(0, 1) != 0) ? x1 + ddx : x1 - ddx;
        y2 = ($urandom_range(0, 1) != 0) ? y1 + ddy : y1 - ddy;
        if (x2 < 0) x2 = 0;
        if (x2 > COORD_MAX) x2 = COORD_MAX;
        if (y2 < 0) y2 = 0;
        if (y2 > COORD_MAX) y2 = COORD_MAX;
        ddx    = (x2 > x1) ? x2 - x1 : x1 - x2;
        ddy    = (y2 > y1) ? y2 - y1 : y1 - y2;
        pixels = ((ddx > ddy) ? ddx : ddy) + 1;
        steps  = pixels;
        shape  = $urandom_range(0, 9);
        if (shape == 0)
            steps = $urandom_range(0, pixels - 1);
        else if (shape < 3)
            steps = pixels + $urandom_range(1, 3);
        add_start(x1, y1, x2, y2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        add_steps(steps);
    endtask

    task automatic add_noise();
        in_t req;
        repeat ($urandom_range(1, 3))
        begin
            req        = step_req();
            req.opcode = ($urandom_range(0, 1) == 0) ? OP_START : OP_STEP;
            pending_reqs.push_back(req);
        end
    endtask

    task automatic write_frame(input logic [FRAME_BITS-1:0] w, input logic [FRAME_BITS-1:0] h);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        frame_sets++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !req_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_reqs.size() != 0)
        begin
            in_data  <= pending_reqs.pop_front();
            in_valid <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0)
                send_gap <= $urandom_range(1, 16);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0)
                recv_gap <= $urandom_range(1, 16);
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin
        wait (accepted_reqs >= HOLD_AT);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_TICKS) @(negedge clk);
        hold_off <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken = 1'b0;
        end
        else
        begin
            req_taken = in_valid && in_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    width_q = cfg_data;
                else
                    height_q = cfg_data;
            end
            if (req_taken)
            begin
                expected_pixels.push_back(rasterize_request(in_data));
                accepted_reqs++;
                if (in_data.opcode == OP_START)
                    line_starts++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: %s", pixel_text(out_data));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (want.pixel_valid)
                        pixel_count++;
                    if (out_data.pixel_valid !== want.pixel_valid
                        || out_data.pixel_visible !== want.pixel_visible
                        || out_data.pixel_x !== want.pixel_x
                        || out_data.pixel_y !== want.pixel_y
                        || out_data.red_out !== want.red_out
                        || out_data.green_out !== want.green_out
                        || out_data.blue_out !== want.blue_out
                        || out_data.last_pixel !== want.last_pixel
                        || out_data.line_idle !== want.line_idle)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                                     pixel_text(want), pixel_text(out_data));
                    end
                end
            end
        end
    end

    initial
    begin
        logic [FRAME_BITS-1:0] w, h;
        bit                    near_origin;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_steps(1);
        add_start(0, 0, COORD_MAX, COORD_MAX, 8'hFF, 8'h00, 8'hFF);
        add_steps(3);
        add_start(COORD_MAX, 0, COORD_MAX - 7, 3, 8'h00, 8'hFF, 8'h00);
        add_steps(3);
        add_start(5, 5, 5, 5, 8'h12, 8'h34, 8'h56);
        add_steps(2);
        add_start(100, COORD_MAX, 101, COORD_MAX, 8'hA5, 8'h5A, 8'hFF);
        add_steps(2);
        add_start(7, 14, 7, 10, 8'h00, 8'h00, 8'h00);
        add_steps(5);
        add_start(9, 0, 7, 5, 8'hFF, 8'hFF, 8'hFF);
        add_steps(3);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    w = 12'd2048;
                    h = 12'd2048;
                end
                1:
                begin
                    w = 12'd0;
                    h = 12'd4095;
                end
                2:
                begin
                    w = 12'd4095;
                    h = 12'd0;
                end
                3:
                begin
                    w = 12'd1;
                    h = 12'd1;
                end
                4:
                begin
                    w = FRAME_BITS'($urandom_range(1, 2048));
                    h = FRAME_BITS'($urandom_range(1, 2048));
                end
                default:
                begin
                    w = FRAME_WIDTH_RESET;
                    h = FRAME_HEIGHT_RESET;
                end
            endcase
            repeat (SETTLE_TICKS) @(negedge clk);
            write_frame(w, h);
            if (p == PHASE_COUNT - 1)
                calm = 1'b1;
            while (pending_reqs.size() < PHASE_ITEMS)
            begin
                near_origin = (p == 3) && ($urandom_range(0, 1) != 0);
                add_random_line(near_origin);
                if ($urandom_range(0, 11) == 0)
                    add_noise();
            end
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        $display("covered %0d requests with %0d line starts and %0d frame settings",
                 accepted_reqs, line_starts, frame_sets + 1);
        $display("checked %0d results, %0d of them pixels, %0d failures",
                 results_checked, pixel_count, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d requests queued and %0d results outstanding",
                 pending_reqs.size(), expected_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[slope_line_rasterizer.f]
rtl/slr_pkg.sv
rtl/slope_line_rasterizer.sv
sim/slope_line_rasterizer_test.sv
